FILE: rtl/erq_pkg.sv
// Shared constants, types and fixed-point scaling for the Euler relative quaternion rotator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package erq_pkg;

  // Field formats
  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANG_W           = 16;
  localparam int QUAT_W          = 16;

  // Q30 internal format
  localparam int          Q30    = 30;
  localparam longint      HALF30 = 64'sd1 <<< (Q30 - 1);
  localparam longint      ONE30  = 64'sd1 <<< Q30;
  localparam int          X_W    = 30;  // radians and series products, below one
  localparam int          TERM_W = 31;  // series terms, cos seed equals one
  localparam int          SC_W   = 32;  // signed sin / cos
  localparam int          MAG_W  = 31;  // magnitudes up to one
  localparam int          B_W    = 33;  // components of the relative rotation
  localparam int          SER_STEPS = 6;

  // Half-angle quadrant reduction, angle unit is 2^-(ANGLE_FRAC_BITS+1) degree of half angle
  localparam longint PI_Q32  = 64'sh3_243F_6A89;
  localparam longint QUARTER = 64'sd90 <<< (ANGLE_FRAC_BITS + 1);
  localparam longint HALFQ   = QUARTER / 2;
  localparam longint OFS     = 4 * QUARTER * ((64'sd32768 / (4 * QUARTER)) + 1);
  localparam longint TMAX    = 64'sd32767 + HALFQ + OFS;
  localparam int     TW      = $clog2(TMAX + 1);
  localparam longint QMAX    = TMAX / QUARTER;
  localparam int     QW      = $clog2(QMAX + 1);
  localparam int     RW      = $clog2(HALFQ + 1);

  // Degrees to Q30 radians: x = |r|*XQ + floor((|r|*XR + DIV/2) / DIV), DIV = 45 << DSH
  localparam longint DIV     = QUARTER * 8;
  localparam longint XQ      = PI_Q32 / DIV;
  localparam longint XR      = PI_Q32 % DIV;
  localparam int     XQW     = $clog2(XQ + 1);
  localparam longint VLO_MAX = HALFQ * XR + DIV / 2;
  localparam int     VW      = $clog2(VLO_MAX + 1);
  localparam int     DSH     = ANGLE_FRAC_BITS + 5;
  localparam longint WMAX    = VLO_MAX >>> DSH;
  localparam int     WW      = $clog2(WMAX + 1);
  localparam int     K45     = WW + 6;
  localparam longint M45     = ((64'sd1 <<< K45) + 44) / 45;
  localparam int     M45W    = $clog2(M45 + 1);

  // Output saturation
  localparam longint SAT_LIM = 64'sd1 <<< QUAT_FRAC_BITS;
  localparam longint SAT_HI  = (SAT_LIM > 32767) ? 64'sd32767 : SAT_LIM;
  localparam longint SAT_LOM = (SAT_LIM > 32768) ? 64'sd32768 : SAT_LIM;

  // Pipeline depths
  localparam int SC_LAT  = 4 + 2 * SER_STEPS + 1;
  localparam int BQ_LAT  = 4;
  localparam int HM_LAT  = 4;
  localparam int TOT_LAT = SC_LAT + BQ_LAT + HM_LAT;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  typedef struct packed {
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } sc_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat16_t;

  typedef struct packed {
    logic signed [B_W-1:0] x;
    logic signed [B_W-1:0] y;
    logic signed [B_W-1:0] z;
    logic signed [B_W-1:0] w;
  } quatb_t;

endpackage

FILE: rtl/erq_sincos.sv
// Half-angle sine/cosine pipeline: quadrant reduction, radian scaling, seven-term series.
// Depends on erq_pkg.
module erq_sincos (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [erq_pkg::ANG_W-1:0]  angle_i,
  output logic                              valid_o,
  output erq_pkg::sc_t                      sc_o
);

  localparam int NSER = 2 * erq_pkg::SER_STEPS;

  typedef struct packed {
    logic [erq_pkg::X_W-1:0]    x2;
    logic [erq_pkg::TERM_W-1:0] ts;
    logic [erq_pkg::TERM_W-1:0] tc;
    logic signed [erq_pkg::SC_W-1:0] s;
    logic signed [erq_pkg::SC_W-1:0] c;
    logic                       rneg;
    erq_pkg::quad_e             quad;
  } ser_t;

  logic [erq_pkg::SC_LAT-1:0] vld_q;

  // stage 1: quadrant split
  logic [erq_pkg::RW-1:0] rmag_d, rmag_q;
  logic                   rneg_d, rneg1_q, rneg2_q, rneg3_q;
  erq_pkg::quad_e         quad_d, quad1_q, quad2_q, quad3_q;

  always_comb begin
    longint             tl;
    longint             rl;
    logic [erq_pkg::TW-1:0] t;
    logic [erq_pkg::QW-1:0] qn;
    tl = longint'(angle_i) + erq_pkg::HALFQ + erq_pkg::OFS;
    t  = erq_pkg::TW'(tl);
    qn = '0;
    for (longint i = 1; i <= erq_pkg::QMAX; i++) begin
      if (longint'(t) >= i * erq_pkg::QUARTER) qn = qn + erq_pkg::QW'(1);
    end
    rl     = longint'(t) - longint'(qn) * erq_pkg::QUARTER - erq_pkg::HALFQ;
    rneg_d = (rl < 0);
    rmag_d = erq_pkg::RW'((rl < 0) ? -rl : rl);
    quad_d = erq_pkg::quad_e'(qn[1:0]);
  end

  // stage 2: split radian scaling into integer and fractional parts
  logic [erq_pkg::RW+erq_pkg::XQW-1:0] hi_d, hi_q;
  logic [erq_pkg::VW-1:0]              vlo_d, vlo_q;

  always_comb begin
    hi_d  = (erq_pkg::RW+erq_pkg::XQW)'(rmag_q) * (erq_pkg::RW+erq_pkg::XQW)'(erq_pkg::XQ);
    vlo_d = erq_pkg::VW'(longint'(rmag_q) * erq_pkg::XR + erq_pkg::DIV / 2);
  end

  // stage 3: divide the fractional part by 45 through a reciprocal
  logic [erq_pkg::X_W-1:0] x_d, x_q;

  always_comb begin
    logic [erq_pkg::WW-1:0]              w;
    logic [erq_pkg::WW+erq_pkg::M45W-1:0] wm;
    w   = erq_pkg::WW'(vlo_q >> erq_pkg::DSH);
    wm  = (erq_pkg::WW+erq_pkg::M45W)'(w) * (erq_pkg::WW+erq_pkg::M45W)'(erq_pkg::M45);
    x_d = erq_pkg::X_W'(hi_q + (erq_pkg::RW+erq_pkg::XQW)'(wm >> erq_pkg::K45));
  end

  // stage 4: square, seed the series
  ser_t ser_q [0:NSER];
  ser_t seed_d;

  always_comb begin
    logic [2*erq_pkg::X_W:0] sq;
    sq = (2*erq_pkg::X_W+1)'(x_q) * (2*erq_pkg::X_W+1)'(x_q)
       + (2*erq_pkg::X_W+1)'(erq_pkg::HALF30);
    seed_d.x2   = erq_pkg::X_W'(sq >> erq_pkg::Q30);
    seed_d.ts   = erq_pkg::TERM_W'(x_q);
    seed_d.tc   = erq_pkg::TERM_W'(erq_pkg::ONE30);
    seed_d.s    = erq_pkg::SC_W'(x_q);
    seed_d.c    = erq_pkg::SC_W'(erq_pkg::ONE30);
    seed_d.rneg = rneg3_q;
    seed_d.quad = quad3_q;
  end

  always_ff @(posedge clk_i) begin
    rmag_q  <= rmag_d;
    rneg1_q <= rneg_d;
    quad1_q <= quad_d;
    hi_q    <= hi_d;
    vlo_q   <= vlo_d;
    rneg2_q <= rneg1_q;
    quad2_q <= quad1_q;
    x_q     <= x_d;
    rneg3_q <= rneg2_q;
    quad3_q <= quad2_q;
    ser_q[0] <= seed_d;
  end

  // series: each step is a product stage and a divide-and-accumulate stage
  for (genvar k = 1; k <= erq_pkg::SER_STEPS; k++) begin : g_ser
    localparam longint unsigned DS = 2 * k * (2 * k + 1);
    localparam longint unsigned DC = (2 * k - 1) * (2 * k);
    localparam int KS = erq_pkg::X_W + $clog2(DS);
    localparam int KC = erq_pkg::X_W + $clog2(DC);
    localparam longint unsigned MS = ((64'd1 << KS) + DS - 1) / DS;
    localparam longint unsigned MC = ((64'd1 << KC) + DC - 1) / DC;
    localparam bit ODD = ((k % 2) == 1);
    localparam int PW = erq_pkg::TERM_W + erq_pkg::X_W + 1;
    localparam int DW = erq_pkg::X_W + 33;

    ser_t a_d, b_d;

    always_comb begin
      logic [PW-1:0] ps, pc;
      a_d = ser_q[2*k-2];
      ps  = PW'(ser_q[2*k-2].ts) * PW'(ser_q[2*k-2].x2) + PW'(erq_pkg::HALF30);
      pc  = PW'(ser_q[2*k-2].tc) * PW'(ser_q[2*k-2].x2) + PW'(erq_pkg::HALF30);
      a_d.ts = erq_pkg::TERM_W'(erq_pkg::X_W'(ps >> erq_pkg::Q30));
      a_d.tc = erq_pkg::TERM_W'(erq_pkg::X_W'(pc >> erq_pkg::Q30));
    end

    always_comb begin
      logic [DW-1:0]           ds, dc;
      logic [erq_pkg::X_W-1:0] tsn, tcn;
      b_d = ser_q[2*k-1];
      ds  = DW'(erq_pkg::X_W'(ser_q[2*k-1].ts)) * DW'(MS);
      dc  = DW'(erq_pkg::X_W'(ser_q[2*k-1].tc)) * DW'(MC);
      tsn = erq_pkg::X_W'(ds >> KS);
      tcn = erq_pkg::X_W'(dc >> KC);
      b_d.ts = erq_pkg::TERM_W'(tsn);
      b_d.tc = erq_pkg::TERM_W'(tcn);
      if (ODD) begin
        b_d.s = ser_q[2*k-1].s - erq_pkg::SC_W'(tsn);
        b_d.c = ser_q[2*k-1].c - erq_pkg::SC_W'(tcn);
      end else begin
        b_d.s = ser_q[2*k-1].s + erq_pkg::SC_W'(tsn);
        b_d.c = ser_q[2*k-1].c + erq_pkg::SC_W'(tcn);
      end
    end

    always_ff @(posedge clk_i) begin
      ser_q[2*k-1] <= a_d;
      ser_q[2*k]   <= b_d;
    end
  end

  // final stage: sign of the remainder, then quadrant map
  erq_pkg::sc_t sc_d, sc_q;

  always_comb begin
    logic signed [erq_pkg::SC_W-1:0] sv;
    logic signed [erq_pkg::SC_W-1:0] cv;
    sv = ser_q[NSER].rneg ? -ser_q[NSER].s : ser_q[NSER].s;
    cv = ser_q[NSER].c;
    unique case (ser_q[NSER].quad)
      erq_pkg::QUAD_0: begin sc_d.s = sv;  sc_d.c = cv;  end
      erq_pkg::QUAD_1: begin sc_d.s = cv;  sc_d.c = -sv; end
      erq_pkg::QUAD_2: begin sc_d.s = -sv; sc_d.c = -cv; end
      erq_pkg::QUAD_3: begin sc_d.s = -cv; sc_d.c = sv;  end
      default:         begin sc_d.s = sv;  sc_d.c = cv;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sc_q <= sc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[erq_pkg::SC_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[erq_pkg::SC_LAT-1];
  assign sc_o    = sc_q;

endmodule

FILE: rtl/erq_bquat.sv
// Relative rotation builder: ZYX quaternion from three half-angle sine/cosine pairs, Q30.
// Depends on erq_pkg.
module erq_bquat (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  erq_pkg::sc_t   roll_i,
  input  erq_pkg::sc_t   pitch_i,
  input  erq_pkg::sc_t   yaw_i,
  output logic           valid_o,
  output erq_pkg::quatb_t b_o
);

  localparam int MW = erq_pkg::MAG_W;

  function automatic logic [MW-1:0] rmul(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [2*MW-1:0] p;
    p = (2*MW)'(a) * (2*MW)'(b) + (2*MW)'(erq_pkg::HALF30);
    return MW'(p >> erq_pkg::Q30);
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [erq_pkg::SC_W-1:0] v);
    return MW'(v[erq_pkg::SC_W-1] ? -v : v);
  endfunction

  function automatic logic signed [erq_pkg::B_W-1:0] sgn(input logic [MW-1:0] m,
                                                         input logic neg);
    logic signed [erq_pkg::B_W-1:0] v;
    v = $signed(erq_pkg::B_W'(m));
    return neg ? -v : v;
  endfunction

  logic [erq_pkg::BQ_LAT-1:0] vld_q;

  // stage 1: magnitudes and signs, order sr cr sp cp sy cy
  logic [MW-1:0] m_d [0:5], m_q [0:5];
  logic [5:0]    n_d, n_q;

  always_comb begin
    m_d[0] = mag(roll_i.s);  n_d[0] = roll_i.s[erq_pkg::SC_W-1];
    m_d[1] = mag(roll_i.c);  n_d[1] = roll_i.c[erq_pkg::SC_W-1];
    m_d[2] = mag(pitch_i.s); n_d[2] = pitch_i.s[erq_pkg::SC_W-1];
    m_d[3] = mag(pitch_i.c); n_d[3] = pitch_i.c[erq_pkg::SC_W-1];
    m_d[4] = mag(yaw_i.s);   n_d[4] = yaw_i.s[erq_pkg::SC_W-1];
    m_d[5] = mag(yaw_i.c);   n_d[5] = yaw_i.c[erq_pkg::SC_W-1];
  end

  // stage 2: roll-pitch products sc cs cc ss
  logic [MW-1:0] p_d [0:3], p_q [0:3];
  logic [3:0]    pn_d, pn_q;
  logic [MW-1:0] ym_q [0:1];
  logic [1:0]    yn_q;

  always_comb begin
    p_d[0] = rmul(m_q[0], m_q[3]); pn_d[0] = n_q[0] ^ n_q[3];
    p_d[1] = rmul(m_q[1], m_q[2]); pn_d[1] = n_q[1] ^ n_q[2];
    p_d[2] = rmul(m_q[1], m_q[3]); pn_d[2] = n_q[1] ^ n_q[3];
    p_d[3] = rmul(m_q[0], m_q[2]); pn_d[3] = n_q[0] ^ n_q[2];
  end

  // stage 3: times yaw terms
  logic [MW-1:0] t_d [0:7], t_q [0:7];
  logic [7:0]    tn_d, tn_q;

  always_comb begin
    t_d[0] = rmul(p_q[0], ym_q[1]); tn_d[0] = pn_q[0] ^ yn_q[1];  // sc*cy
    t_d[1] = rmul(p_q[1], ym_q[0]); tn_d[1] = pn_q[1] ^ yn_q[0];  // cs*sy
    t_d[2] = rmul(p_q[1], ym_q[1]); tn_d[2] = pn_q[1] ^ yn_q[1];  // cs*cy
    t_d[3] = rmul(p_q[0], ym_q[0]); tn_d[3] = pn_q[0] ^ yn_q[0];  // sc*sy
    t_d[4] = rmul(p_q[2], ym_q[0]); tn_d[4] = pn_q[2] ^ yn_q[0];  // cc*sy
    t_d[5] = rmul(p_q[3], ym_q[1]); tn_d[5] = pn_q[3] ^ yn_q[1];  // ss*cy
    t_d[6] = rmul(p_q[2], ym_q[1]); tn_d[6] = pn_q[2] ^ yn_q[1];  // cc*cy
    t_d[7] = rmul(p_q[3], ym_q[0]); tn_d[7] = pn_q[3] ^ yn_q[0];  // ss*sy
  end

  // stage 4: signed sums
  erq_pkg::quatb_t b_d, b_q;

  always_comb begin
    b_d.x = sgn(t_q[0], tn_q[0]) - sgn(t_q[1], tn_q[1]);
    b_d.y = sgn(t_q[2], tn_q[2]) + sgn(t_q[3], tn_q[3]);
    b_d.z = sgn(t_q[4], tn_q[4]) - sgn(t_q[5], tn_q[5]);
    b_d.w = sgn(t_q[6], tn_q[6]) + sgn(t_q[7], tn_q[7]);
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    n_q     <= n_d;
    p_q     <= p_d;
    pn_q    <= pn_d;
    ym_q[0] <= m_q[4];
    ym_q[1] <= m_q[5];
    yn_q    <= n_q[5:4];
    t_q     <= t_d;
    tn_q    <= tn_d;
    b_q     <= b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[erq_pkg::BQ_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[erq_pkg::BQ_LAT-1];
  assign b_o     = b_q;

endmodule

FILE: rtl/erq_ham.sv
// Hamilton product A*B with rounding back to the quaternion format and saturation.
// Depends on erq_pkg.
module erq_ham (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  erq_pkg::quat16_t a_i,
  input  erq_pkg::quatb_t  b_i,
  output logic             valid_o,
  output erq_pkg::quat16_t q_o
);

  localparam int PW = erq_pkg::QUAT_W + erq_pkg::B_W;
  localparam int SW = PW + 2;
  localparam int RM = SW - erq_pkg::Q30;

  function automatic logic signed [PW-1:0] pmul(input logic signed [erq_pkg::QUAT_W-1:0] a,
                                                input logic signed [erq_pkg::B_W-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic signed [erq_pkg::QUAT_W-1:0] sat(input logic [RM-1:0] m,
                                                            input logic neg);
    logic signed [erq_pkg::QUAT_W:0] v;
    if (neg) begin
      v = (m > RM'(erq_pkg::SAT_LOM)) ? -(erq_pkg::QUAT_W+1)'(erq_pkg::SAT_LOM)
                                      : -$signed((erq_pkg::QUAT_W+1)'(m));
    end else begin
      v = (m > RM'(erq_pkg::SAT_HI)) ? (erq_pkg::QUAT_W+1)'(erq_pkg::SAT_HI)
                                     : $signed((erq_pkg::QUAT_W+1)'(m));
    end
    return erq_pkg::QUAT_W'(v);
  endfunction

  logic [erq_pkg::HM_LAT-1:0] vld_q;

  // stage 1: sixteen products, row per output component
  logic signed [PW-1:0] pr_d [0:15], pr_q [0:15];

  always_comb begin
    pr_d[0]  = pmul(a_i.w, b_i.x);  pr_d[1]  = pmul(a_i.x, b_i.w);
    pr_d[2]  = pmul(a_i.y, b_i.z);  pr_d[3]  = pmul(a_i.z, b_i.y);
    pr_d[4]  = pmul(a_i.w, b_i.y);  pr_d[5]  = pmul(a_i.x, b_i.z);
    pr_d[6]  = pmul(a_i.y, b_i.w);  pr_d[7]  = pmul(a_i.z, b_i.x);
    pr_d[8]  = pmul(a_i.w, b_i.z);  pr_d[9]  = pmul(a_i.x, b_i.y);
    pr_d[10] = pmul(a_i.y, b_i.x);  pr_d[11] = pmul(a_i.z, b_i.w);
    pr_d[12] = pmul(a_i.w, b_i.w);  pr_d[13] = pmul(a_i.x, b_i.x);
    pr_d[14] = pmul(a_i.y, b_i.y);  pr_d[15] = pmul(a_i.z, b_i.z);
  end

  // stage 2: exact sums
  logic signed [SW-1:0] sm_d [0:3], sm_q [0:3];

  always_comb begin
    sm_d[0] = SW'(pr_q[0])  + SW'(pr_q[1])  + SW'(pr_q[2])  - SW'(pr_q[3]);
    sm_d[1] = SW'(pr_q[4])  - SW'(pr_q[5])  + SW'(pr_q[6])  + SW'(pr_q[7]);
    sm_d[2] = SW'(pr_q[8])  + SW'(pr_q[9])  - SW'(pr_q[10]) + SW'(pr_q[11]);
    sm_d[3] = SW'(pr_q[12]) - SW'(pr_q[13]) - SW'(pr_q[14]) - SW'(pr_q[15]);
  end

  // stage 3: round magnitude half away from zero
  logic [RM-1:0] rm_d [0:3], rm_q [0:3];
  logic [3:0]    rn_d, rn_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [SW-1:0] av;
      av      = sm_q[i][SW-1] ? SW'(-sm_q[i]) : SW'(sm_q[i]);
      rm_d[i] = RM'((av + SW'(erq_pkg::HALF30)) >> erq_pkg::Q30);
      rn_d[i] = sm_q[i][SW-1];
    end
  end

  // stage 4: saturate into the output register
  erq_pkg::quat16_t q_d, q_q;

  always_comb begin
    q_d.x = sat(rm_q[0], rn_q[0]);
    q_d.y = sat(rm_q[1], rn_q[1]);
    q_d.z = sat(rm_q[2], rn_q[2]);
    q_d.w = sat(rm_q[3], rn_q[3]);
  end

  always_ff @(posedge clk_i) begin
    pr_q <= pr_d;
    sm_q <= sm_d;
    rm_q <= rm_d;
    rn_q <= rn_d;
    q_q  <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[erq_pkg::HM_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[erq_pkg::HM_LAT-1];
  assign q_o     = q_q;

endmodule

FILE: rtl/euler_relative_quaternion_rotate_top.sv
// Top level of the Euler relative quaternion rotator.
// Depends on erq_pkg, erq_sincos, erq_bquat and erq_ham.
//
// One request per clock: busy_o stays low, so a request is taken at every edge
// with start_i high, and its rotated quaternion appears on the quat_out ports
// with done_o high for one cycle, after the three parallel half-angle
// sine/cosine pipelines, the relative rotation quaternion builder and the
// Hamilton product with rounding and saturation have handled it. Results
// leave in request order and cannot be held off, so take them on done_o.
// Angles are degrees with 6 fractional bits and wrap periodically; the input
// quaternion is Q2.14, taken as given without normalization, and each output
// component saturates to plus or minus one. No state, no clearing pass after
// reset.
module euler_relative_quaternion_rotate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] roll_deg_i,
  input  logic [15:0] pitch_deg_i,
  input  logic [15:0] yaw_deg_i,
  input  logic [15:0] quat_in_x_i,
  input  logic [15:0] quat_in_y_i,
  input  logic [15:0] quat_in_z_i,
  input  logic [15:0] quat_in_w_i,
  output logic        done_o,
  output logic [15:0] quat_out_x_o,
  output logic [15:0] quat_out_y_o,
  output logic [15:0] quat_out_z_o,
  output logic [15:0] quat_out_w_o
);

  localparam int A_DLY = erq_pkg::SC_LAT + erq_pkg::BQ_LAT;

  logic             accept;
  logic             v_roll, v_pitch, v_yaw, v_b, v_out;
  erq_pkg::sc_t     sc_roll, sc_pitch, sc_yaw;
  erq_pkg::quatb_t  b_rel;
  erq_pkg::quat16_t a_in, q_out;
  erq_pkg::quat16_t a_dly_q [0:A_DLY-1];

  // Fully pipelined: never push back on the requester.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign a_in.x = $signed(quat_in_x_i);
  assign a_in.y = $signed(quat_in_y_i);
  assign a_in.z = $signed(quat_in_z_i);
  assign a_in.w = $signed(quat_in_w_i);

  // Three identical half-angle sine/cosine pipelines run side by side.
  erq_sincos u_sc_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i ($signed(roll_deg_i)),
    .valid_o (v_roll),
    .sc_o    (sc_roll)
  );

  erq_sincos u_sc_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i ($signed(pitch_deg_i)),
    .valid_o (v_pitch),
    .sc_o    (sc_pitch)
  );

  erq_sincos u_sc_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i ($signed(yaw_deg_i)),
    .valid_o (v_yaw),
    .sc_o    (sc_yaw)
  );

  // Build the relative rotation B in Q30.
  erq_bquat u_bquat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_roll & v_pitch & v_yaw),
    .roll_i  (sc_roll),
    .pitch_i (sc_pitch),
    .yaw_i   (sc_yaw),
    .valid_o (v_b),
    .b_o     (b_rel)
  );

  // Hold the orientation A alongside, so it meets B at the product stage.
  always_ff @(posedge clk_i) begin
    a_dly_q[0] <= a_in;
    for (int i = 1; i < A_DLY; i++) begin
      a_dly_q[i] <= a_dly_q[i-1];
    end
  end

  erq_ham u_ham (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_b),
    .a_i     (a_dly_q[A_DLY-1]),
    .b_i     (b_rel),
    .valid_o (v_out),
    .q_o     (q_out)
  );

  assign done_o       = v_out;
  assign quat_out_x_o = q_out.x;
  assign quat_out_y_o = q_out.y;
  assign quat_out_z_o = q_out.z;
  assign quat_out_w_o = q_out.w;

endmodule

FILE: rtl/erq_checker.sv
// Port-level checker for the Euler relative quaternion rotator, bound to the top level.
// Depends on erq_pkg and euler_relative_quaternion_rotate_top.
module erq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] quat_out_x_o,
  input logic [15:0] quat_out_y_o,
  input logic [15:0] quat_out_z_o,
  input logic [15:0] quat_out_w_o
);

  logic [erq_pkg::TOT_LAT-1:0] req_q;

  // Track accepted requests to predict result strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= {req_q[erq_pkg::TOT_LAT-2:0], start_i & ~busy_o};
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == 1'b0)
    else $error("busy asserted on a fully pipelined block");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == req_q[erq_pkg::TOT_LAT-1])
    else $error("result strobe does not match request latency");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      (longint'($signed(quat_out_x_o)) <= erq_pkg::SAT_HI) &&
      (longint'($signed(quat_out_x_o)) >= -erq_pkg::SAT_LOM) &&
      (longint'($signed(quat_out_y_o)) <= erq_pkg::SAT_HI) &&
      (longint'($signed(quat_out_y_o)) >= -erq_pkg::SAT_LOM) &&
      (longint'($signed(quat_out_z_o)) <= erq_pkg::SAT_HI) &&
      (longint'($signed(quat_out_z_o)) >= -erq_pkg::SAT_LOM) &&
      (longint'($signed(quat_out_w_o)) <= erq_pkg::SAT_HI) &&
      (longint'($signed(quat_out_w_o)) >= -erq_pkg::SAT_LOM))
    else $error("output component beyond saturation limit");

endmodule

bind euler_relative_quaternion_rotate_top erq_checker u_erq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .quat_out_x_o (quat_out_x_o),
  .quat_out_y_o (quat_out_y_o),
  .quat_out_z_o (quat_out_z_o),
  .quat_out_w_o (quat_out_w_o)
);
